FILE: design/selective_repeat_window_control_unit_macros.svh
// assertion macros shared by the window control rtl
// expects clk and rst_n in the scope of each use
`ifndef SELECTIVE_REPEAT_WINDOW_CONTROL_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_WINDOW_CONTROL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SRWC_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("srwc check failed");
`define SRWC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srwc implication failed");
`else
`define SRWC_ASSERT(label, cond)
`define SRWC_ASSERT_IMP(label, ante, cons)
`endif

`endif

FILE: design/srwc_pkg.sv
// shared types, codes and sequence helpers of the window control unit
// no dependencies
`default_nettype none

package srwc_pkg;

  localparam int SEQ_MAX     = 31;
  localparam int SEQ_W       = 5;
  localparam int NR_BUFS     = (SEQ_MAX + 1) / 2;
  localparam int SLOT_W      = 4;
  localparam int QUEUE_DEPTH = 2;

  // event kinds
  localparam logic [2:0] KIND_PKT_READY  = 3'd0;
  localparam logic [2:0] KIND_LINK_READY = 3'd1;
  localparam logic [2:0] KIND_FRAME      = 3'd2;
  localparam logic [2:0] KIND_DATA_TO    = 3'd3;
  localparam logic [2:0] KIND_ACK_TO     = 3'd4;

  // frame types
  localparam logic [1:0] FT_DATA = 2'd0;
  localparam logic [1:0] FT_ACK  = 2'd1;
  localparam logic [1:0] FT_NAK  = 2'd2;

  // actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_FETCH     = 3'd1;
  localparam logic [2:0] ACT_TRANSMIT  = 3'd2;
  localparam logic [2:0] ACT_STORE     = 3'd3;
  localparam logic [2:0] ACT_DELIVER   = 3'd4;
  localparam logic [2:0] ACT_STOP_DT   = 3'd5;
  localparam logic [2:0] ACT_START_ACK = 3'd6;

  // classified commands
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_PKT  = 4'd1;
  localparam logic [3:0] OP_LINK = 4'd2;
  localparam logic [3:0] OP_BAD  = 4'd3;
  localparam logic [3:0] OP_DATA = 4'd4;
  localparam logic [3:0] OP_NAK  = 4'd5;
  localparam logic [3:0] OP_ACK  = 4'd6;
  localparam logic [3:0] OP_DTO  = 4'd7;
  localparam logic [3:0] OP_ATO  = 4'd8;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [3:0] op;
    seq_t       seq;
    seq_t       ack;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] ftype;
    seq_t       seq;
    seq_t       ack;
    slot_t      slot;
  } item_t;

  function automatic seq_t seq_inc(input seq_t k);
    return (k < SEQ_W'(SEQ_MAX)) ? k + 1'b1 : '0;
  endfunction

  function automatic logic in_window(input seq_t a, input seq_t b, input seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic slot_t slot_of(input seq_t s);
    return s[SLOT_W-1:0];
  endfunction

  // piggybacked ack: one below the receive low edge
  function automatic seq_t ack_of(input seq_t r);
    return (r == '0) ? SEQ_W'(SEQ_MAX) : r - 1'b1;
  endfunction

  function automatic item_t make_item(input logic [2:0] action, input logic [1:0] ftype,
                                      input seq_t seq, input seq_t ack, input slot_t slot);
    item_t it;
    it.action = action;
    it.ftype  = ftype;
    it.seq    = seq;
    it.ack    = ack;
    it.slot   = slot;
    return it;
  endfunction

endpackage

`default_nettype wire

FILE: design/selective_repeat_window_control_unit.sv
// selective-repeat window control: an event of n actions (at most 35) is popped from the queue head,
// its actions pass through a hold register and the output register, one action per cycle
// while out_tready holds, and the last one carries out_tlast; events are handled one at a time
// input transfers are taken while the command queue has room
// synchronous active-low reset: window edges zero, receive high edge 16, naks allowed,
// link not ready, slot map empty, queue and output register empty
`default_nettype none

module selective_repeat_window_control_unit
  import srwc_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // frame_ok, frame_type, frame_seq, rx_ack
  input  wire logic [2:0]  in_tuser,  // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // out_type, out_seq, out_ack, slot, network_enable
  output logic [2:0]       out_tuser, // action
  output logic             out_tlast
);

  cmd_t  front_cmd, head_cmd;
  logic  q_full, head_valid, pop, in_fire;
  item_t item;
  logic  item_en;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  srwc_front u_front (
    .kind       (in_tuser),
    .frame_ok   (in_tdata[0]),
    .frame_type (in_tdata[2:1]),
    .frame_seq  (in_tdata[7:3]),
    .rx_ack     (in_tdata[12:8]),
    .cmd        (front_cmd)
  );

  srwc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  srwc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (item),
    .out_en    (item_en),
    .out_last  (out_tlast)
  );

  assign out_tuser = item.action;
  assign out_tdata = {7'd0, item_en, item.slot, item.ack, item.seq, item.ftype};

endmodule

`default_nettype wire

FILE: design/srwc_front.sv
// front end: decodes an incoming event into a command for the queue
// depends on srwc_pkg
`default_nettype none

module srwc_front
  import srwc_pkg::*;
(
  input  wire logic [2:0] kind,
  input  wire logic       frame_ok,
  input  wire logic [1:0] frame_type,
  input  wire seq_t       frame_seq,
  input  wire seq_t       rx_ack,
  output cmd_t            cmd
);

  always_comb begin
    cmd.seq = frame_seq;
    cmd.ack = rx_ack;
    case (kind)
      KIND_PKT_READY:  cmd.op = OP_PKT;
      KIND_LINK_READY: cmd.op = OP_LINK;
      KIND_FRAME: begin
        if (!frame_ok) begin
          cmd.op = OP_BAD;
        end else begin
          case (frame_type)
            FT_DATA: cmd.op = OP_DATA;
            FT_NAK:  cmd.op = OP_NAK;
            default: cmd.op = OP_ACK;
          endcase
        end
      end
      KIND_DATA_TO:    cmd.op = OP_DTO;
      KIND_ACK_TO:     cmd.op = OP_ATO;
      default:         cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/srwc_queue.sv
// short command queue between front end and sequencer
// depends on srwc_pkg and the assertion macros
`default_nettype none
`include "selective_repeat_window_control_unit_macros.svh"

module srwc_queue
  import srwc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `SRWC_ASSERT(a_count_range, count_r <= CW'(DEPTH))
  `SRWC_ASSERT_IMP(a_pop_nonempty, pop, count_r != '0)
  `SRWC_ASSERT_IMP(a_push_room, push && !pop, count_r != CW'(DEPTH))

endmodule

`default_nettype wire

FILE: design/srwc_engine.sv
// sequencer: window state and action generation for one command at a time
// depends on srwc_pkg and the assertion macros
`default_nettype none
`include "selective_repeat_window_control_unit_macros.svh"

module srwc_engine
  import srwc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output item_t     out_item,
  output logic      out_en,
  output logic      out_last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_PKTTX = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_DELIV = 3'd4;
  localparam logic [2:0] ST_ACKS  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  seq_t              send_low_r, send_low_nxt;
  seq_t              send_next_r, send_next_nxt;
  seq_t              recv_low_r, recv_low_nxt;
  seq_t              recv_high_r, recv_high_nxt;
  seq_t              outst_r, outst_nxt;
  logic              nak_ok_r, nak_ok_nxt;
  logic              link_r, link_nxt;
  logic [NR_BUFS-1:0] arrived_r, arrived_nxt;
  logic              delivered_r, delivered_nxt;
  logic              en_r, en_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  item_t             hold_item_r, hold_item_nxt;
  logic              out_valid_r, out_valid_nxt;
  item_t             out_item_r, out_item_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_en_r, out_en_nxt;

  logic  en_now, emit_ok, go, produce;
  item_t prod_item;
  seq_t  ack_ofs, ack_cnt, outst_after, nak_seq, cur_ack;
  logic  tx_pred, link_after;

  assign en_now  = (outst_r < SEQ_W'(NR_BUFS)) && link_r;
  assign emit_ok = !out_valid_r || out_ready;
  assign go      = !hold_valid_r || emit_ok;
  assign cur_ack = ack_of(recv_low_r);

  // network enable after the event, worked out from the head command
  always_comb begin
    nak_seq = seq_inc(cmd.ack);
    ack_ofs = cmd.ack - send_low_r;
    ack_cnt = (ack_ofs < outst_r) ? ack_ofs + 1'b1 : '0;
    outst_after = outst_r;
    tx_pred = 1'b0;
    case (cmd.op)
      OP_PKT: begin
        tx_pred = en_now;
        if (en_now) begin
          outst_after = outst_r + 1'b1;
        end
      end
      OP_BAD: tx_pred = nak_ok_r;
      OP_DATA: begin
        tx_pred     = (cmd.seq != recv_low_r) && nak_ok_r;
        outst_after = outst_r - ack_cnt;
      end
      OP_NAK: begin
        tx_pred     = in_window(send_low_r, nak_seq, send_next_r);
        outst_after = outst_r - ack_cnt;
      end
      OP_ACK:  outst_after = outst_r - ack_cnt;
      OP_DTO:  tx_pred = 1'b1;
      OP_ATO:  tx_pred = 1'b1;
      default: tx_pred = 1'b0;
    endcase
    if (cmd.op == OP_LINK) begin
      link_after = 1'b1;
    end else if (tx_pred) begin
      link_after = 1'b0;
    end else begin
      link_after = link_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    send_low_nxt   = send_low_r;
    send_next_nxt  = send_next_r;
    recv_low_nxt   = recv_low_r;
    recv_high_nxt  = recv_high_r;
    outst_nxt      = outst_r;
    nak_ok_nxt     = nak_ok_r;
    link_nxt       = link_r;
    arrived_nxt    = arrived_r;
    delivered_nxt  = delivered_r;
    en_nxt         = en_r;
    hold_valid_nxt = hold_valid_r;
    hold_item_nxt  = hold_item_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    out_en_nxt     = out_en_r;
    cmd_pop        = 1'b0;
    produce        = 1'b0;
    prod_item      = '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop       = 1'b1;
          cmd_nxt       = cmd;
          en_nxt        = (outst_after < SEQ_W'(NR_BUFS)) && link_after;
          delivered_nxt = 1'b0;
          state_nxt     = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (go) begin
          state_nxt = ST_FIN;
          case (cmd_r.op)
            OP_PKT: begin
              if (en_now) begin
                produce   = 1'b1;
                prod_item = make_item(ACT_FETCH, FT_DATA, '0, '0, slot_of(send_next_r));
                state_nxt = ST_PKTTX;
              end
            end
            OP_LINK: link_nxt = 1'b1;
            OP_BAD: begin
              if (nak_ok_r) begin
                produce    = 1'b1;
                prod_item  = make_item(ACT_TRANSMIT, FT_NAK, '0, cur_ack, '0);
                nak_ok_nxt = 1'b0;
                link_nxt   = 1'b0;
              end
            end
            OP_DATA: begin
              produce = 1'b1;
              if ((cmd_r.seq != recv_low_r) && nak_ok_r) begin
                prod_item  = make_item(ACT_TRANSMIT, FT_NAK, '0, cur_ack, '0);
                nak_ok_nxt = 1'b0;
                link_nxt   = 1'b0;
              end else begin
                prod_item = make_item(ACT_START_ACK, FT_DATA, '0, '0, '0);
              end
              state_nxt = ST_STORE;
            end
            OP_NAK: begin
              if (in_window(send_low_r, seq_inc(cmd_r.ack), send_next_r)) begin
                produce   = 1'b1;
                prod_item = make_item(ACT_TRANSMIT, FT_DATA, seq_inc(cmd_r.ack), cur_ack,
                                      slot_of(seq_inc(cmd_r.ack)));
                link_nxt  = 1'b0;
              end
              state_nxt = ST_ACKS;
            end
            OP_ACK: state_nxt = ST_ACKS;
            OP_DTO: begin
              produce   = 1'b1;
              prod_item = make_item(ACT_TRANSMIT, FT_DATA, send_low_r, cur_ack,
                                    slot_of(send_low_r));
              link_nxt  = 1'b0;
            end
            OP_ATO: begin
              produce   = 1'b1;
              prod_item = make_item(ACT_TRANSMIT, FT_ACK, '0, cur_ack, '0);
              link_nxt  = 1'b0;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_PKTTX: begin
        if (go) begin
          produce       = 1'b1;
          prod_item     = make_item(ACT_TRANSMIT, FT_DATA, send_next_r, cur_ack,
                                    slot_of(send_next_r));
          outst_nxt     = outst_r + 1'b1;
          send_next_nxt = seq_inc(send_next_r);
          link_nxt      = 1'b0;
          state_nxt     = ST_FIN;
        end
      end
      ST_STORE: begin
        if (go) begin
          if (in_window(recv_low_r, cmd_r.seq, recv_high_r) &&
              !arrived_r[slot_of(cmd_r.seq)]) begin
            arrived_nxt[slot_of(cmd_r.seq)] = 1'b1;
            produce   = 1'b1;
            prod_item = make_item(ACT_STORE, FT_DATA, '0, '0, slot_of(cmd_r.seq));
            state_nxt = ST_DELIV;
          end else begin
            state_nxt = ST_ACKS;
          end
        end
      end
      ST_DELIV: begin
        if (go) begin
          if (arrived_r[slot_of(recv_low_r)]) begin
            produce       = 1'b1;
            prod_item     = make_item(ACT_DELIVER, FT_DATA, '0, '0, slot_of(recv_low_r));
            nak_ok_nxt    = 1'b1;
            arrived_nxt[slot_of(recv_low_r)] = 1'b0;
            recv_low_nxt  = seq_inc(recv_low_r);
            recv_high_nxt = seq_inc(recv_high_r);
            delivered_nxt = 1'b1;
          end else begin
            if (delivered_r) begin
              produce   = 1'b1;
              prod_item = make_item(ACT_START_ACK, FT_DATA, '0, '0, '0);
            end
            state_nxt = ST_ACKS;
          end
        end
      end
      ST_ACKS: begin
        if (go) begin
          if ((outst_r != '0) && in_window(send_low_r, cmd_r.ack, send_next_r)) begin
            produce      = 1'b1;
            prod_item    = make_item(ACT_STOP_DT, FT_DATA, '0, '0, slot_of(send_low_r));
            outst_nxt    = outst_r - 1'b1;
            send_low_nxt = seq_inc(send_low_r);
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_item_nxt   = hold_valid_r ? hold_item_r : make_item(ACT_NONE, FT_DATA, '0, '0, '0);
          out_last_nxt   = 1'b1;
          out_en_nxt     = en_r;
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // a held item leaves once the next one exists, so only the final one carries last
    if (produce) begin
      if (hold_valid_r) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = hold_item_r;
        out_last_nxt  = 1'b0;
        out_en_nxt    = en_r;
      end
      hold_item_nxt  = prod_item;
      hold_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      send_low_r   <= '0;
      send_next_r  <= '0;
      recv_low_r   <= '0;
      recv_high_r  <= SEQ_W'(NR_BUFS);
      outst_r      <= '0;
      nak_ok_r     <= 1'b1;
      link_r       <= 1'b0;
      arrived_r    <= '0;
      delivered_r  <= 1'b0;
      en_r         <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      send_low_r   <= send_low_nxt;
      send_next_r  <= send_next_nxt;
      recv_low_r   <= recv_low_nxt;
      recv_high_r  <= recv_high_nxt;
      outst_r      <= outst_nxt;
      nak_ok_r     <= nak_ok_nxt;
      link_r       <= link_nxt;
      arrived_r    <= arrived_nxt;
      delivered_r  <= delivered_nxt;
      en_r         <= en_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    hold_item_r <= hold_item_nxt;
    out_item_r  <= out_item_nxt;
    out_last_r  <= out_last_nxt;
    out_en_r    <= out_en_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_last  = out_last_r;
  assign out_en    = out_en_r;

  `SRWC_ASSERT_IMP(a_en_predicted, state_r == ST_FIN, en_r == en_now)
  `SRWC_ASSERT(a_send_span, outst_r == SEQ_W'(send_next_r - send_low_r))
  `SRWC_ASSERT(a_outst_max, outst_r <= SEQ_W'(NR_BUFS))
  `SRWC_ASSERT(a_recv_span, SEQ_W'(recv_high_r - recv_low_r) == SEQ_W'(NR_BUFS))

endmodule

`default_nettype wire
